FILE: sv/kfa_pkg.sv
// Shared types and constants for the scalar Kalman angle filter.
package kfa_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned GainW  = 17;
  localparam int unsigned VarW   = 33;
  localparam int unsigned SumW   = 34;
  localparam int unsigned AddrW  = 3;

  localparam logic [GainW-1:0] GainOne = 17'h10000;

  localparam logic [DataW-1:0] TimeStepRst  = 32'd655;
  localparam logic [DataW-1:0] ProcNoiseRst = 32'd66;
  localparam logic [DataW-1:0] MeasNoiseRst = 32'd6554;
  localparam logic [DataW-1:0] InitAngleRst = 32'd0;
  localparam logic [DataW-1:0] InitVarRst   = 32'd65536;

  typedef enum logic [AddrW-1:0] {
    REG_TIME_STEP    = 3'd0,
    REG_PROC_NOISE   = 3'd1,
    REG_MEAS_NOISE   = 3'd2,
    REG_INIT_ANGLE   = 3'd3,
    REG_INIT_VAR     = 3'd4
  } kfa_reg_e;

  typedef struct packed {
    logic             done;
    logic [GainW-1:0] quot;
  } kfa_div_res_t;

endpackage

FILE: sv/kfa_div.sv
// Restoring divider for the gain: floor(num * 2^16 / den), one quotient bit a cycle.
module kfa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [kfa_pkg::VarW-1:0]    num_i,
  input  logic [kfa_pkg::SumW-1:0]    den_i,
  output kfa_pkg::kfa_div_res_t       res_o
);

  localparam int unsigned RemW = kfa_pkg::SumW + 1;

  logic [RemW-1:0]              rem_q;
  logic [kfa_pkg::SumW-1:0]     den_q;
  logic [kfa_pkg::GainW-1:0]    quot_q;
  logic [4:0]                   cnt_q;
  logic                         done_q;
  logic                         ge;
  logic [RemW-1:0]              rem_sub;

  assign ge      = rem_q >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= 5'(kfa_pkg::GainW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 5'd1;
      done_q <= (cnt_q == 5'd1);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {2'b00, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      // remainder stays below den, so the top bit dropped by the shift is zero
      rem_q  <= {rem_sub[RemW-2:0], 1'b0};
      quot_q <= {quot_q[kfa_pkg::GainW-2:0], ge};
    end
  end

  // zero divisor gives a zero gain
  assign res_o.done = done_q;
  assign res_o.quot = (den_q == '0) ? '0 : quot_q;

endmodule

FILE: sv/scalar_kalman_angle_filter.sv
// Top level of the scalar Kalman angle filter: sequencer, shared multiplier, state.
//
// Input channel s_axis: one item per sensor sample, gyro rate and accelerometer
// angle in tdata, the first flag in tuser (reloads initial angle and variance).
// Output channel m_axis: one item per sample, new angle and variance in tdata.
// Configuration: cfg_we_i writes register cfg_addr_i with cfg_wdata_i; write
// only while no sample is in flight. Unknown indexes are ignored.
// From acceptance to its result showing on m_axis, an item goes through
// three passes through the single shared multiplier, a restoring
// divider for the gain, and the adds and saturations between them. The next
// item can be accepted in the cycle after the result is loaded, so only one
// item is in work at a time.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in the output register; if the receiver stalls, the next item is still
// accepted and worked on, and its result waits until the register frees up.
// Reset clears the angle and variance to zero and loads the register defaults.
module scalar_kalman_angle_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kfa_pkg::AddrW-1:0]   cfg_addr_i,
  input  logic [kfa_pkg::DataW-1:0]   cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,   // [31:0] gyro_rate, [63:32] accel_angle
  input  logic                        s_axis_tuser,   // [0] first
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata    // [31:0] angle_estimate, [63:32] variance_estimate
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_STEP, ST_PRED, ST_DIV_GO, ST_DIV_WAIT, ST_INNOV,
    ST_MUL_INNOV, ST_ANGLE, ST_MUL_VAR, ST_VAR, ST_DONE
  } state_e;

  localparam int unsigned ProdW = 67;
  localparam int unsigned WideW = 52;

  function automatic logic [31:0] sat_s32(input logic signed [WideW-1:0] v);
    logic [31:0] r;
    if ((&v[WideW-1:31]) || !(|v[WideW-1:31])) r = v[31:0];
    else if (v[WideW-1]) r = 32'h8000_0000;
    else r = 32'h7fff_ffff;
    return r;
  endfunction

  state_e                        state_q;
  logic [31:0]                   ts_q, pn_q, mn_q, ia_q, iv_q;
  logic signed [31:0]            angle_q, rate_q, meas_q, xp_q;
  logic [31:0]                   var_q;
  logic [kfa_pkg::VarW-1:0]      pp_q;
  logic signed [32:0]            innov_q;
  logic [kfa_pkg::GainW-1:0]     k_q;
  logic signed [ProdW-1:0]       prod_q, prod_d;
  logic signed [32:0]            mul_a;
  logic signed [33:0]            mul_b;
  logic                          m_valid_q;
  logic [63:0]                   m_data_q;
  logic                          div_start;
  logic [kfa_pkg::SumW-1:0]      div_den;
  kfa_pkg::kfa_div_res_t         div_res;
  logic signed [WideW-1:0]       step_sum, corr_sum;
  logic [kfa_pkg::GainW-1:0]     gain_comp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= kfa_pkg::TimeStepRst;
      pn_q <= kfa_pkg::ProcNoiseRst;
      mn_q <= kfa_pkg::MeasNoiseRst;
      ia_q <= kfa_pkg::InitAngleRst;
      iv_q <= kfa_pkg::InitVarRst;
    end else if (cfg_we_i) begin
      unique case (kfa_pkg::kfa_reg_e'(cfg_addr_i))
        kfa_pkg::REG_TIME_STEP:  ts_q <= cfg_wdata_i;
        kfa_pkg::REG_PROC_NOISE: pn_q <= cfg_wdata_i;
        kfa_pkg::REG_MEAS_NOISE: mn_q <= cfg_wdata_i;
        kfa_pkg::REG_INIT_ANGLE: ia_q <= cfg_wdata_i;
        kfa_pkg::REG_INIT_VAR:   iv_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand selection
  assign gain_comp = kfa_pkg::GainOne - k_q;

  always_comb begin
    unique case (state_q)
      ST_MUL_STEP: begin
        mul_a = {1'b0, ts_q};
        mul_b = {{2{rate_q[31]}}, rate_q};
      end
      ST_MUL_INNOV: begin
        mul_a = {16'b0, k_q};
        mul_b = {innov_q[32], innov_q};
      end
      default: begin
        mul_a = {16'b0, gain_comp};
        mul_b = {1'b0, pp_q};
      end
    endcase
  end

  assign prod_d = ProdW'(mul_a * mul_b);

  // prod >>> 16 is the floor shift; results fit in WideW-1 bits
  assign step_sum = {{(WideW-32){angle_q[31]}}, angle_q}
                  + {prod_q[ProdW-1], prod_q[ProdW-1:16]};
  assign corr_sum = {{(WideW-32){xp_q[31]}}, xp_q}
                  + {prod_q[ProdW-1], prod_q[ProdW-1:16]};

  assign div_start = (state_q == ST_DIV_GO);
  assign div_den   = {1'b0, pp_q} + {2'b00, mn_q};

  kfa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (pp_q),
    .den_i   (div_den),
    .res_o   (div_res)
  );

  // Sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      angle_q   <= '0;
      var_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser) begin
              angle_q <= ia_q;
              var_q   <= iv_q;
            end
            state_q <= ST_MUL_STEP;
          end
        end
        ST_MUL_STEP:  state_q <= ST_PRED;
        ST_PRED:      state_q <= ST_DIV_GO;
        ST_DIV_GO:    state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT:  if (div_res.done) state_q <= ST_INNOV;
        ST_INNOV:     state_q <= ST_MUL_INNOV;
        ST_MUL_INNOV: state_q <= ST_ANGLE;
        ST_ANGLE: begin
          angle_q <= sat_s32(corr_sum);
          state_q <= ST_MUL_VAR;
        end
        ST_MUL_VAR:   state_q <= ST_VAR;
        ST_VAR: begin
          var_q   <= (|prod_q[ProdW-1:48]) ? 32'hffff_ffff : prod_q[47:16];
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_data_q <= {var_q, angle_q};
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      rate_q <= s_axis_tdata[31:0];
      meas_q <= s_axis_tdata[63:32];
    end
    if (state_q == ST_MUL_STEP || state_q == ST_MUL_INNOV || state_q == ST_MUL_VAR) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_PRED) begin
      xp_q <= sat_s32(step_sum);
      pp_q <= {1'b0, var_q} + {1'b0, pn_q};
    end
    if (state_q == ST_DIV_WAIT && div_res.done) k_q <= div_res.quot;
    if (state_q == ST_INNOV) innov_q <= {meas_q[31], meas_q} - {xp_q[31], xp_q};
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INNOV |-> k_q <= kfa_pkg::GainOne)
    else $error("gain above one");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
    else $error("result shown without a finished item");

endmodule
